[src/matp_pkg.sv]
`timescale 1ns / 1ps

package matp_pkg;

	localparam int OCTETS = 6;
	localparam int ADDR_W = 48;
	localparam logic [4:0] EXPECT_LEN = 5'(3 * OCTETS - 1);
	localparam logic [4:0] CHAR_MAX = 5'd31;
	localparam logic [2:0] OCTET_LAST = 3'(OCTETS);
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_END = 8'h00;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_FIRST,
		PH_SECOND,
		PH_SEP
	} phase_t;

	typedef struct packed {
		phase_t             phase;
		logic [2:0]         octet_count;
		logic [4:0]         char_count;
		logic [3:0]         high_nibble;
		logic [ADDR_W-1:0]  address_acc;
	} parse_state_t;

	typedef struct packed {
		logic              valid;
		logic [ADDR_W-1:0] address;
		logic              status;
	} parse_result_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] value;
	} hex_digit_t;

	function automatic hex_digit_t hex_value(input logic [7:0] c);
		hex_digit_t d;
		d = '0;
		if (c >= 8'h30 && c <= 8'h39) begin
			d.ok = 1'b1;
			d.value = 4'(c - 8'h30);
		end else if (c >= 8'h61 && c <= 8'h66) begin
			d.ok = 1'b1;
			d.value = 4'(c - 8'h57);
		end else if (c >= 8'h41 && c <= 8'h46) begin
			d.ok = 1'b1;
			d.value = 4'(c - 8'h37);
		end
		return d;
	endfunction

	function automatic logic [4:0] count_inc(input logic [4:0] n);
		return (n == CHAR_MAX) ? n : n + 5'd1;
	endfunction

endpackage

[src/matp_in_if.sv]
`timescale 1ns / 1ps

interface matp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;
	logic       start_req;

	modport source (output valid, output ch, output start_req, input ready);
	modport sink (input valid, input ch, input start_req, output ready);
endinterface

[src/matp_out_if.sv]
`timescale 1ns / 1ps

interface matp_out_if;
	logic        valid;
	logic        ready;
	logic [47:0] address;
	logic        status;

	modport source (output valid, output address, output status, input ready);
	modport sink (input valid, input address, input status, output ready);
endinterface

[src/matp_step.sv]
`timescale 1ns / 1ps

module matp_step (
	input  logic [7:0]             ch,
	input  logic                   start_req,
	input  matp_pkg::parse_state_t cur,
	output matp_pkg::parse_state_t nxt,
	output matp_pkg::parse_result_t res
);

	matp_pkg::parse_state_t st;
	matp_pkg::hex_digit_t   hd;
	logic                   do_first;
	logic                   emit;
	logic                   emit_ok;
	logic [7:0]             octet_val;
	logic [2:0]             octet_next;

	assign hd = matp_pkg::hex_value(ch);

	// Next-state logic.
	always_comb begin
		st = cur;
		if (start_req) begin
			st = '0;
			st.phase = matp_pkg::PH_FIRST;
		end
		nxt = st;
		do_first = 1'b0;
		emit = 1'b0;
		emit_ok = 1'b0;
		octet_val = '0;
		octet_next = st.octet_count + 3'd1;
		unique case (st.phase)
			matp_pkg::PH_IDLE: begin
			end
			matp_pkg::PH_SEP: begin
				if (ch == matp_pkg::CH_COLON) begin
					nxt.char_count = matp_pkg::count_inc(st.char_count);
					nxt.phase = matp_pkg::PH_FIRST;
				end else begin
					do_first = 1'b1;
				end
			end
			matp_pkg::PH_FIRST: begin
				do_first = 1'b1;
			end
			matp_pkg::PH_SECOND: begin
				priority if (hd.ok) begin
					octet_val = {st.high_nibble, hd.value};
					nxt.char_count = matp_pkg::count_inc(st.char_count);
				end else if (ch == matp_pkg::CH_COLON) begin
					octet_val = {4'h0, st.high_nibble};
					nxt.char_count = matp_pkg::count_inc(st.char_count);
				end else if (ch == matp_pkg::CH_END) begin
					octet_val = {4'h0, st.high_nibble};
				end else begin
					emit = 1'b1;
				end
				if (!emit) begin
					nxt.address_acc = {st.address_acc[matp_pkg::ADDR_W-9:0], octet_val};
					nxt.octet_count = octet_next;
					if (octet_next == matp_pkg::OCTET_LAST) begin
						emit = 1'b1;
						emit_ok = (nxt.char_count == matp_pkg::EXPECT_LEN);
					end else if (ch == matp_pkg::CH_END) begin
						emit = 1'b1;
					end else begin
						nxt.phase = matp_pkg::PH_SEP;
					end
				end
			end
			default: begin
			end
		endcase
		if (do_first) begin
			if (hd.ok) begin
				nxt.high_nibble = hd.value;
				nxt.char_count = matp_pkg::count_inc(st.char_count);
				nxt.phase = matp_pkg::PH_SECOND;
			end else begin
				emit = 1'b1;
			end
		end
		if (emit) begin
			nxt.phase = matp_pkg::PH_IDLE;
		end
	end

	// Result logic.
	always_comb begin
		res.valid = emit;
		res.status = !emit_ok;
		res.address = emit_ok ? nxt.address_acc : '0;
	end

endmodule

[src/mac_address_text_parser_core.sv]
`timescale 1ns / 1ps

// Parses a MAC address string delivered one character per request and gives at most one
// result per string, whose address holds the six octets with the first in the top byte.
// A new character is accepted in every cycle unless a stall holds the input register;
// its effect is computed by the combinational parse step from the input register and is
// registered in the result register. The rate of one character per cycle holds while
// no result waits; while a result waits for the receiver, the parse step stalls and the input
// register can still take one more character.

module mac_address_text_parser_core (
	input  logic             clk,
	input  logic             arst_n,
	matp_in_if.sink          chars,
	matp_out_if.source       result
);

	logic                    valid_s1;
	logic [7:0]              ch_s1;
	logic                    start_s1;
	matp_pkg::parse_state_t  state_q;
	matp_pkg::parse_state_t  state_next;
	matp_pkg::parse_result_t step_res;
	logic                    out_valid_q;
	logic [47:0]             address_q;
	logic                    status_q;
	logic                    out_free;
	logic                    advance;

	assign out_free = !out_valid_q || result.ready;
	assign advance = valid_s1 && out_free;
	assign chars.ready = !valid_s1 || out_free;

	matp_step u_step (
		.ch        (ch_s1),
		.start_req (start_s1),
		.cur       (state_q),
		.nxt       (state_next),
		.res       (step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.ready) begin
			valid_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.valid && chars.ready) begin
			ch_s1 <= chars.ch;
			start_s1 <= chars.start_req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && step_res.valid) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && step_res.valid) begin
			address_q <= step_res.address;
			status_q <= step_res.status;
		end
	end

	assign result.valid = out_valid_q;
	assign result.address = address_q;
	assign result.status = status_q;

endmodule
